FILE: rtl/aabb_frustum_cull_top_defines.svh
// Assertion helpers used by the top-level RTL.
`ifndef AABB_FRUSTUM_CULL_TOP_DEFINES_SVH
`define AABB_FRUSTUM_CULL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afc: next-cycle check failed");

`endif

FILE: rtl/afc_pkg.sv
package afc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int FIELD_W     = 32;
  localparam int CFG_W       = 64;
  localparam int NUM_CFG     = 8;
  localparam int CFG_SEL_W   = $clog2(NUM_CFG);
  localparam int CFG_IDX_W   = 8;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int MASK_W      = 6;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CMP_W       = SUM_W + 1;
  localparam int W_ROW       = 3;

  localparam logic [CFG_W-1:0] ONE_Q  = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_Q << (CFG_W / 2);

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    ONE_Q, '0, ONE_HI, '0, '0, ONE_Q, '0, ONE_HI
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  typedef struct packed {
    logic [MASK_W-1:0] bits;
    logic              wzero;
  } corner_res_t;

  function automatic coord_t sext_coord(input logic [FIELD_W-1:0] v);
    return coord_t'(v[COORD_WIDTH-1:0]);
  endfunction

endpackage

FILE: rtl/aabb_frustum_cull_top.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | min_x_i .. max_z_i
// result   | out       | out_valid_o / out_stall_i | visible_o, outside_mask_o
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One box per cycle unless a held result stalls the pipeline; an accepted
// transaction passes through each registered stage below in order.
// Stages: products, partial sums, clip sums, plane compare, mask reduce.
// Reset loads the identity matrix and empties the pipeline; no clearing pass.
// The pipeline advances as one; a stalled result freezes every stage and
// in_stall_o follows, so a bubble behind a stalled result is not squeezed out.
// Config writes are always taken; indexes beyond the last register are dropped.
`include "aabb_frustum_cull_top_defines.svh"

module aabb_frustum_cull_top
  import afc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FIELD_W-1:0]   min_x_i,
  input  logic [FIELD_W-1:0]   min_y_i,
  input  logic [FIELD_W-1:0]   min_z_i,
  input  logic [FIELD_W-1:0]   max_x_i,
  input  logic [FIELD_W-1:0]   max_y_i,
  input  logic [FIELD_W-1:0]   max_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 visible_o,
  output logic [MASK_W-1:0]    outside_mask_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Config registers and the matrix view of them.
  logic [CFG_W-1:0] cfg_q [NUM_CFG];
  coord_t mat [NUM_ROWS][NUM_ROWS];
  coord_t coord [NUM_AXES][2];

  // Pipeline registers.
  logic  en;
  logic  v1_q, v2_q, v3_q, v4_q, out_valid_q;
  prod_t prod_d [NUM_ROWS][NUM_AXES][2];
  prod_t prod_q [NUM_ROWS][NUM_AXES][2];
  sum_t  pxy_d [NUM_ROWS][4];
  sum_t  pxy_q [NUM_ROWS][4];
  sum_t  pzw_d [NUM_ROWS][2];
  sum_t  pzw_q [NUM_ROWS][2];
  sum_t  clip_d [NUM_CORNERS][NUM_ROWS];
  sum_t  clip_q [NUM_CORNERS][NUM_ROWS];
  corner_res_t corner_res [NUM_CORNERS];
  logic [MASK_W-1:0] mask_d, mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_CFG))) begin
      cfg_q[cfg_index_i[CFG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  // Row r, column c sits in register 2r + c/2, low half for even columns.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        mat[r][c] = ((c & 1) == 1) ? sext_coord(cfg_q[2*r + (c >> 1)][CFG_W-1:FIELD_W])
                                   : sext_coord(cfg_q[2*r + (c >> 1)][FIELD_W-1:0]);
      end
    end
  end

  // Advance everything unless a finished result is held by the sink.
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  assign coord[0][0] = sext_coord(min_x_i);
  assign coord[1][0] = sext_coord(min_y_i);
  assign coord[2][0] = sext_coord(min_z_i);
  assign coord[0][1] = sext_coord(max_x_i);
  assign coord[1][1] = sext_coord(max_y_i);
  assign coord[2][1] = sext_coord(max_z_i);

  // Stage 1: the eight corners share products, so only min and max of
  // each axis are multiplied by each entry of the first three matrix columns.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int h = 0; h < 2; h++) begin
          prod_d[r][a][h] = PROD_W'(mat[r][a]) * PROD_W'(coord[a][h]);
        end
      end
    end
  end

  // Stage 2: x+y pairs for the four x/y choices, z plus the translation term.
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < 4; k++) begin
        pxy_d[r][k] = SUM_W'(prod_q[r][0][k & 1]) + SUM_W'(prod_q[r][1][k >> 1]);
      end
      for (int h = 0; h < 2; h++) begin
        pzw_d[r][h] = SUM_W'(prod_q[r][2][h]) + (SUM_W'(mat[r][3]) <<< FRAC_BITS);
      end
    end
  end

  // Stage 3: full clip coordinate of each corner.
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        clip_d[k][r] = pxy_q[r][k & 3] + pzw_q[r][k >> 2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      pxy_q  <= pxy_d;
      pzw_q  <= pzw_d;
      clip_q <= clip_d;
      mask_q <= mask_d;
    end
  end

  // Stage 4: plane tests, one unit per corner.
  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    afc_corner_test u_test (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .clip_i (clip_q[k]),
      .res_o  (corner_res[k])
    );
  end

  // Stage 5: a plane culls only if every corner is outside it; any corner
  // with zero w clears the whole mask.
  always_comb begin
    mask_d = '1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      mask_d = mask_d & corner_res[k].bits;
    end
    for (int k = 0; k < NUM_CORNERS; k++) begin
      if (corner_res[k].wzero) begin
        mask_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outside_mask_o = mask_q;
  assign visible_o      = (mask_q == '0);

  `AFC_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v1_q)
  `AFC_ASSERT_NEXT(a_last_stage_out, v4_q && en, out_valid_q)
  `AFC_ASSERT_IMPL(a_frozen_on_stall, out_valid_q && out_stall_i, in_stall_o)

endmodule

FILE: rtl/afc_corner_test.sv
module afc_corner_test
  import afc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  sum_t        clip_i [NUM_ROWS],
  output corner_res_t res_o
);

  corner_res_t res_d, res_q;
  logic signed [CMP_W-1:0] w_ext;
  logic signed [CMP_W-1:0] s_sum [NUM_AXES];
  logic signed [CMP_W-1:0] d_sum [NUM_AXES];
  logic wpos;

  // Compare against -w and +w without dividing; sign of w picks the direction.
  always_comb begin
    w_ext       = CMP_W'(clip_i[W_ROW]);
    wpos        = !w_ext[CMP_W-1];
    res_d.wzero = (w_ext == '0);
    for (int a = 0; a < NUM_AXES; a++) begin
      s_sum[a] = CMP_W'(clip_i[a]) + w_ext;
      d_sum[a] = CMP_W'(clip_i[a]) - w_ext;
      res_d.bits[2*a]   = wpos ? s_sum[a][CMP_W-1]
                               : (!s_sum[a][CMP_W-1] && (s_sum[a] != '0));
      res_d.bits[2*a+1] = wpos ? (!d_sum[a][CMP_W-1] && (d_sum[a] != '0))
                               : d_sum[a][CMP_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: test/aabb_frustum_cull_top_test.sv
module aabb_frustum_cull_top_test;
  import afc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 5;
  localparam int RANDOM_BOXES = 1030;

  typedef logic signed [127:0] clip_t;

  typedef struct packed {
    logic [FIELD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  typedef struct packed {
    logic              visible;
    logic [MASK_W-1:0] mask;
  } cull_t;

  // One row of the directed table: the box, and a typed-in result where the
  // answer is obvious (has_known = 0 means the predictor decides).
  typedef struct packed {
    box_t  box;
    logic  has_known;
    cull_t known;
  } vector_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  box_t               drive_box = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               visible_o;
  logic [MASK_W-1:0]  outside_mask_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  logic [CFG_W-1:0] matrix_regs [NUM_CFG];
  cull_t            pending_culls [$];
  int               fail_count = 0;
  bit               source_done = 1'b0;

  aabb_frustum_cull_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .min_x_i(drive_box.min_x), .min_y_i(drive_box.min_y), .min_z_i(drive_box.min_z),
    .max_x_i(drive_box.max_x), .max_y_i(drive_box.max_y), .max_z_i(drive_box.max_z),
    .out_valid_o, .out_stall_i, .visible_o, .outside_mask_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pull one signed entry out of the packed matrix registers.
  function automatic clip_t matrix_entry(int row, int col);
    logic [CFG_W-1:0] r;
    logic [31:0] half;
    r = matrix_regs[row * 2 + col / 2];
    half = (col % 2) ? r[63:32] : r[31:0];
    return clip_t'(coord_t'(half[COORD_WIDTH-1:0]));
  endfunction

  function automatic clip_t clip_coord(int row, clip_t x, clip_t y, clip_t z);
    return matrix_entry(row, 0) * x + matrix_entry(row, 1) * y +
           matrix_entry(row, 2) * z + (matrix_entry(row, 3) <<< FRAC_BITS);
  endfunction

  // Frustum cull one box: AND the per-corner outside bits over all corners;
  // any corner sitting on w == 0 clears the whole mask.
  function automatic cull_t cull_box(box_t b);
    clip_t lo [3];
    clip_t hi [3];
    clip_t x, y, z, w, c;
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] bits;
    cull_t res;
    lo[0] = clip_t'(coord_t'(b.min_x[COORD_WIDTH-1:0]));
    lo[1] = clip_t'(coord_t'(b.min_y[COORD_WIDTH-1:0]));
    lo[2] = clip_t'(coord_t'(b.min_z[COORD_WIDTH-1:0]));
    hi[0] = clip_t'(coord_t'(b.max_x[COORD_WIDTH-1:0]));
    hi[1] = clip_t'(coord_t'(b.max_y[COORD_WIDTH-1:0]));
    hi[2] = clip_t'(coord_t'(b.max_z[COORD_WIDTH-1:0]));
    mask = '1;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      x = k[0] ? hi[0] : lo[0];
      y = k[1] ? hi[1] : lo[1];
      z = k[2] ? hi[2] : lo[2];
      w = clip_coord(W_ROW, x, y, z);
      if (w == 0) begin
        mask = '0;
      end else begin
        for (int a = 0; a < NUM_AXES; a++) begin
          c = clip_coord(a, x, y, z);
          if (w > 0) begin
            bits[2*a]   = (c < -w);
            bits[2*a+1] = (c > w);
          end else begin
            bits[2*a]   = (c > -w);
            bits[2*a+1] = (c < w);
          end
        end
        mask &= bits;
      end
    end
    res.visible = (mask == 0);
    res.mask = mask;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] pack_pair(logic [31:0] c0, logic [31:0] c1);
    return {c1, c0};
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Write one matrix register; hold until the transaction is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < CFG_IDX_W'(NUM_CFG)) matrix_regs[idx[CFG_SEL_W-1:0]] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [CFG_W-1:0] m [NUM_CFG]);
    for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), m[i]);
  endtask

  // Drain the pipeline before touching the matrix.
  task automatic wait_idle();
    while (pending_culls.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // Offer one box at the falling edge; hold it until accepted.
  task automatic send_box(box_t b, cull_t want, bit use_known);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      drive_box <= box_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    drive_box <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_culls.push_back(use_known ? want : cull_box(b));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int spread);
    case (spread)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    int spread;
    spread = $urandom_range(0, 3);
    b.min_x = rand_coord(spread);
    b.min_y = rand_coord(spread);
    b.min_z = rand_coord(spread);
    b.max_x = rand_coord(spread);
    b.max_y = rand_coord(spread);
    b.max_z = rand_coord(spread);
    // Mostly well-ordered boxes; leave some inverted on purpose.
    if ($urandom_range(0, 4) != 0) begin
      if ($signed(b.min_x) > $signed(b.max_x)) {b.min_x, b.max_x} = {b.max_x, b.min_x};
      if ($signed(b.min_y) > $signed(b.max_y)) {b.min_y, b.max_y} = {b.max_y, b.min_y};
      if ($signed(b.min_z) > $signed(b.max_z)) {b.min_z, b.max_z} = {b.max_z, b.min_z};
    end
    return b;
  endfunction

  // Small random matrix entries keep boxes landing on both sides of planes.
  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
    endcase
  endfunction

  // Result side: stall at random, compare each transaction in order.
  initial begin
    cull_t want;
    int hold;
    forever begin
      @(negedge clk_i);
      hold = gap_length();
      out_stall_i <= (hold != 0);
      repeat (hold > 0 ? hold - 1 : 0) @(negedge clk_i);
      if (hold != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_culls.size() == 0) begin
          $error("unexpected result: visible=%0b outside_mask=%0h", visible_o, outside_mask_o);
          fail_count++;
        end else begin
          want = pending_culls.pop_front();
          if (visible_o !== want.visible) begin
            $error("visible: expected %0b, got %0b", want.visible, visible_o);
            fail_count++;
          end
          if (outside_mask_o !== want.mask) begin
            $error("outside_mask: expected %0h, got %0h", want.mask, outside_mask_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus.
  initial begin
    vector_t directed [$];
    logic [CFG_W-1:0] mtx [NUM_CFG];
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] TWO = 32'h0002_0000;
    localparam logic [31:0] NEG_TWO = 32'hfffe_0000;
    localparam logic [31:0] MAXC = 32'h7fff_ffff;
    localparam logic [31:0] MINC = 32'h8000_0000;

    for (int i = 0; i < NUM_CFG; i++) matrix_regs[i] = CFG_RESET[i];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity after reset: a unit-centered box is visible, a box shifted
    // past a plane has that plane's bit set.
    directed.push_back('{'{'0, '0, '0, '0, '0, '0}, 1'b1, '{1'b1, 6'h00}});
    directed.push_back('{'{NEG_TWO, NEG_TWO, NEG_TWO, TWO, TWO, TWO}, 1'b1, '{1'b1, 6'h00}});
    directed.push_back('{'{TWO, '0, '0, TWO, '0, '0}, 1'b1, '{1'b0, 6'h02}});
    directed.push_back('{'{NEG_TWO, '0, '0, NEG_TWO, '0, '0}, 1'b1, '{1'b0, 6'h01}});
    directed.push_back('{'{'0, TWO, '0, '0, TWO, '0}, 1'b1, '{1'b0, 6'h08}});
    directed.push_back('{'{'0, NEG_TWO, '0, '0, NEG_TWO, '0}, 1'b1, '{1'b0, 6'h04}});
    directed.push_back('{'{'0, '0, TWO, '0, '0, TWO}, 1'b1, '{1'b0, 6'h20}});
    directed.push_back('{'{'0, '0, NEG_TWO, '0, '0, NEG_TWO}, 1'b1, '{1'b0, 6'h10}});
    // On the plane exactly counts as inside.
    directed.push_back('{'{ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1, '{1'b1, 6'h00}});
    directed.push_back('{'{TWO, TWO, TWO, TWO, TWO, TWO}, 1'b1, '{1'b0, 6'h2a}});
    // Field extremes and an inverted box.
    directed.push_back('{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1'b1, '{1'b0, 6'h2a}});
    directed.push_back('{'{MINC, MINC, MINC, MINC, MINC, MINC}, 1'b1, '{1'b0, 6'h15}});
    directed.push_back('{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 1'b0, '0});
    directed.push_back('{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 1'b0, '0});
    directed.push_back('{'{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                           32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555}, 1'b0, '0});

    foreach (directed[i]) send_box(directed[i].box, directed[i].known, directed[i].has_known);
    release_input();
    wait_idle();

    // Zero w row: every corner skipped, always visible.
    mtx = CFG_RESET;
    mtx[7] = '0;
    load_matrix(mtx);
    send_box('{TWO, TWO, TWO, TWO, TWO, TWO}, '{1'b1, 6'h00}, 1'b1);
    send_box('{MINC, MINC, MINC, MINC, MINC, MINC}, '{1'b1, 6'h00}, 1'b1);
    // Index beyond the register file is dropped.
    release_input();
    wait_idle();
    write_reg(CFG_IDX_W'(NUM_CFG), '1);
    write_reg(8'hff, '1);

    // Negative w (mirrored identity) flips the comparison direction.
    mtx[7] = pack_pair('0, 32'hffff_0000);
    load_matrix(mtx);
    send_box('{TWO, '0, '0, TWO, '0, '0}, '{1'b0, 6'h01}, 1'b1);
    send_box('{NEG_TWO, NEG_TWO, '0, TWO, NEG_TWO, '0}, '0, 1'b0);
    release_input();
    wait_idle();

    // Extreme matrix: all-ones and sign-bit entries.
    for (int i = 0; i < NUM_CFG; i++) mtx[i] = (i % 2) ? '1 : {2{MINC}};
    load_matrix(mtx);
    send_box('{MAXC, MINC, MAXC, MINC, MAXC, MINC}, '0, 1'b0);
    send_box('{ONE, ONE, ONE, TWO, TWO, TWO}, '0, 1'b0);
    release_input();
    wait_idle();
    for (int i = 0; i < NUM_CFG; i++) mtx[i] = {2{MAXC}};
    load_matrix(mtx);
    send_box('{MAXC, MINC, MAXC, MINC, MAXC, MINC}, '0, 1'b0);
    release_input();
    wait_idle();

    // Random phases: a fresh matrix every so often, back to identity at times.
    for (int n = 0; n < RANDOM_BOXES; n++) begin
      if (n % 100 == 0) begin
        release_input();
        wait_idle();
        for (int i = 0; i < NUM_CFG; i++)
          mtx[i] = (n % 300 == 0) ? CFG_RESET[i] : pack_pair(rand_entry(), rand_entry());
        // Keep w mostly positive and nonzero so planes get exercised.
        if (n % 200 == 100) mtx[7] = pack_pair(rand_entry(), ONE);
        load_matrix(mtx);
      end
      send_box(rand_box(), '0, 1'b0);
    end
    release_input();
    source_done = 1'b1;
  end

  // Wrap up once the source is done and every result has come back.
  initial begin
    wait (source_done);
    while (pending_culls.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH * 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: aabb_frustum_cull_top.f
+incdir+rtl
rtl/afc_pkg.sv
rtl/afc_corner_test.sv
rtl/aabb_frustum_cull_top.sv
test/aabb_frustum_cull_top_test.sv
